[rtl/hba_pkg.sv]
// Shared types and constants for the bucketed histogram accumulator.
// Holds the beat structs, action and register codes, and reset values.
// No dependencies.
package hba_pkg;

	localparam int CNT_W           = 48;
	localparam int SUM_W           = 64;
	localparam int IDX_W           = 3;
	localparam int ACT_W           = 2;
	localparam int BCNT_W          = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int NUM_EDGES       = 5;
	localparam int MAX_BUCKETS_DEF = 6;

	typedef enum logic [ACT_W-1:0] {
		ACT_OBSERVE = 2'd0,
		ACT_READ    = 2'd1,
		ACT_CLEAR   = 2'd2
	} hba_action_t;

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_VALUE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_ONE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_TWO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THREE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_FOUR    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_FIVE    = 3'd6;

	localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 3'd6;
	localparam logic [SUM_W-1:0]  TOP_VALUE_RST    = 64'd1099511627776;
	localparam logic [NUM_EDGES-1:0][SUM_W-1:0] EDGES_RST = {
		64'd1048576, 64'd65536, 64'd4096, 64'd256, 64'd16
	};

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic signed [SUM_W-1:0] sample_value;
		logic [IDX_W-1:0]        read_index;
	} hba_req_t;

	typedef struct packed {
		logic                    bucket_hit;
		logic [IDX_W-1:0]        hit_index;
		logic [CNT_W-1:0]        bucket_obs;
		logic signed [SUM_W-1:0] bucket_total;
		logic [CNT_W-1:0]        all_obs;
		logic signed [SUM_W-1:0] all_total;
	} hba_rsp_t;

	// bucket lookup outcome handed from the selector to the update stage
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} hba_sel_t;

endpackage

[rtl/hba_bucket_sel.sv]
// Bucket selector: parallel upper-bound compares and first-match pick.
// Depends on hba_pkg.
module hba_bucket_sel import hba_pkg::*; #(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  logic [BCNT_W-1:0]                 bucket_count,
	input  logic [SUM_W-1:0]                  top_value,
	input  logic [NUM_EDGES-1:0][SUM_W-1:0]   edges,
	input  logic signed [SUM_W-1:0]           sample_value,
	output hba_sel_t                          sel
);

	logic [BCNT_W-1:0]      used_n;
	logic [MAX_BUCKETS-1:0] match;

	// zero acts as one bucket, anything above the build limit clamps to it
	always_comb begin
		if (bucket_count == '0) begin
			used_n = BCNT_W'(1);
		end else if (bucket_count > BCNT_W'(MAX_BUCKETS)) begin
			used_n = BCNT_W'(MAX_BUCKETS);
		end else begin
			used_n = bucket_count;
		end
	end

	for (genvar k = 0; k < MAX_BUCKETS; k++) begin : g_bound
		logic signed [SUM_W-1:0] high;
		if (k < MAX_BUCKETS - 1) begin : g_mid
			// edge minus one wraps, so an edge at the most negative value opens this bucket
			assign high = (BCNT_W'(k + 1) < used_n) ? $signed(edges[k] - SUM_W'(1))
			                                        : $signed(top_value);
		end else begin : g_last
			assign high = $signed(top_value);
		end
		assign match[k] = (BCNT_W'(k) < used_n) && (sample_value <= high);
	end

	always_comb begin
		sel.hit = |match;
		sel.idx = '0;
		for (int k = MAX_BUCKETS - 1; k >= 0; k--) begin
			if (match[k]) begin
				sel.idx = IDX_W'(k);
			end
		end
	end

endmodule

[rtl/bucketed_histogram_accumulator.sv]
// Variable-bin histogram accumulator: the top level.
// Uses hba_pkg and hba_bucket_sel.
//
// Request channel (req_valid / req_stall / req_data) carries one beat per
// item: observe a sample, read one bucket, or clear every count and sum.
// Each beat yields exactly one response beat on rsp_valid / rsp_stall /
// rsp_data, in order. A beat passes through the input register, the bucket
// compare stage and the update stage into the response register. One beat
// per cycle is sustained while the receiver does not stall; the six bucket
// bound compares sit in one stage and the 64-bit sum and 48-bit count update
// in the next, and the update stage writes the counters in the same cycle so
// back-to-back beats always see fresh totals.
// When the receiver stalls, the whole pipe holds and one more request beat
// lands in a skid register; req_stall then rises until the pipe moves again.
// Configuration writes (cfg_valid with cfg_ready, always high) take effect on
// the next edge; issue them only while no beat is in flight. Counts and sums
// are not touched by configuration writes.
// Reset clears every count, sum and valid flag and loads the default bucket
// edges, top value and bucket count; no clearing pass is needed.
module bucketed_histogram_accumulator import hba_pkg::*; #(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  hba_req_t             req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output hba_rsp_t             rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SUM_W-1:0]     cfg_data
);

	localparam int BIDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

	// configuration
	logic [BCNT_W-1:0]               bucket_count_q;
	logic [SUM_W-1:0]                top_value_q;
	logic [NUM_EDGES-1:0][SUM_W-1:0] edges_q;

	// flow control
	logic     adv;
	logic     req_take;
	logic     skid_full_q;
	hba_req_t skid_q;

	// pipeline
	logic                    vld_s1;
	hba_req_t                req_s1;
	hba_sel_t                sel_c;
	logic                    vld_s2;
	logic [ACT_W-1:0]        action_s2;
	logic signed [SUM_W-1:0] value_s2;
	logic [IDX_W-1:0]        ridx_s2;
	hba_sel_t                sel_s2;
	logic                    rsp_valid_q;
	hba_rsp_t                rsp_q;

	// histogram state
	logic [CNT_W-1:0] bin_cnt_q [MAX_BUCKETS];
	logic [SUM_W-1:0] bin_sum_q [MAX_BUCKETS];
	logic [CNT_W-1:0] grand_cnt_q;
	logic [SUM_W-1:0] grand_sum_q;

	// update stage signals
	logic [IDX_W-1:0]  bin_idx;
	logic              bin_ok;
	logic [BIDX_W-1:0] bin_sel;
	logic [CNT_W-1:0]  bin_cnt_cur;
	logic [SUM_W-1:0]  bin_sum_cur;
	logic [CNT_W-1:0]  bin_cnt_inc;
	logic [SUM_W-1:0]  bin_sum_inc;
	logic [CNT_W-1:0]  grand_cnt_inc;
	logic [SUM_W-1:0]  grand_sum_inc;
	logic              upd;
	hba_rsp_t          rsp_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RST;
			top_value_q    <= TOP_VALUE_RST;
			edges_q        <= EDGES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BUCKET_COUNT: bucket_count_q <= cfg_data[BCNT_W-1:0];
				REG_TOP_VALUE:    top_value_q    <= cfg_data;
				REG_EDGE_ONE:     edges_q[0]     <= cfg_data;
				REG_EDGE_TWO:     edges_q[1]     <= cfg_data;
				REG_EDGE_THREE:   edges_q[2]     <= cfg_data;
				REG_EDGE_FOUR:    edges_q[3]     <= cfg_data;
				REG_EDGE_FIVE:    edges_q[4]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipe moves unless a finished beat is held by the receiver
	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_take  = req_valid && !skid_full_q;
	assign req_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				skid_full_q <= 1'b0;
				vld_s1      <= skid_full_q || req_take;
				vld_s2      <= vld_s1;
				rsp_valid_q <= vld_s2;
			end else if (req_take) begin
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && req_take) begin
			skid_q <= req_data;
		end
		if (adv) begin
			req_s1    <= skid_full_q ? skid_q : req_data;
			action_s2 <= req_s1.action;
			value_s2  <= req_s1.sample_value;
			ridx_s2   <= req_s1.read_index;
			sel_s2    <= sel_c;
			rsp_q     <= rsp_c;
		end
	end

	hba_bucket_sel #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_sel (
		.bucket_count (bucket_count_q),
		.top_value    (top_value_q),
		.edges        (edges_q),
		.sample_value (req_s1.sample_value),
		.sel          (sel_c)
	);

	// update stage: one bucket address, either the hit bucket or the read index
	always_comb begin
		bin_idx = (action_s2 == ACT_READ) ? ridx_s2 : sel_s2.idx;
		bin_ok  = bin_idx < IDX_W'(MAX_BUCKETS);
		bin_sel = bin_idx[BIDX_W-1:0];
		if (bin_ok) begin
			bin_cnt_cur = bin_cnt_q[bin_sel];
			bin_sum_cur = bin_sum_q[bin_sel];
		end else begin
			bin_cnt_cur = '0;
			bin_sum_cur = '0;
		end
		bin_cnt_inc   = (&bin_cnt_cur) ? bin_cnt_cur : bin_cnt_cur + CNT_W'(1);
		bin_sum_inc   = bin_sum_cur + value_s2;
		grand_cnt_inc = (&grand_cnt_q) ? grand_cnt_q : grand_cnt_q + CNT_W'(1);
		grand_sum_inc = grand_sum_q + value_s2;
	end

	always_comb begin
		rsp_c.bucket_hit   = 1'b0;
		rsp_c.hit_index    = '0;
		rsp_c.bucket_obs   = '0;
		rsp_c.bucket_total = '0;
		rsp_c.all_obs      = grand_cnt_q;
		rsp_c.all_total    = grand_sum_q;
		case (action_s2)
			ACT_OBSERVE: begin
				rsp_c.all_obs   = grand_cnt_inc;
				rsp_c.all_total = grand_sum_inc;
				if (sel_s2.hit) begin
					rsp_c.bucket_hit   = 1'b1;
					rsp_c.hit_index    = sel_s2.idx;
					rsp_c.bucket_obs   = bin_cnt_inc;
					rsp_c.bucket_total = bin_sum_inc;
				end
			end
			ACT_READ: begin
				rsp_c.hit_index    = ridx_s2;
				rsp_c.bucket_obs   = bin_cnt_cur;
				rsp_c.bucket_total = bin_sum_cur;
			end
			ACT_CLEAR: begin
				rsp_c.all_obs   = '0;
				rsp_c.all_total = '0;
			end
			default: ;
		endcase
	end

	assign upd = adv && vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grand_cnt_q <= '0;
			grand_sum_q <= '0;
			for (int k = 0; k < MAX_BUCKETS; k++) begin
				bin_cnt_q[k] <= '0;
				bin_sum_q[k] <= '0;
			end
		end else if (upd) begin
			case (action_s2)
				ACT_OBSERVE: begin
					grand_cnt_q <= grand_cnt_inc;
					grand_sum_q <= grand_sum_inc;
					if (sel_s2.hit && bin_ok) begin
						bin_cnt_q[bin_sel] <= bin_cnt_inc;
						bin_sum_q[bin_sel] <= bin_sum_inc;
					end
				end
				ACT_CLEAR: begin
					grand_cnt_q <= '0;
					grand_sum_q <= '0;
					for (int k = 0; k < MAX_BUCKETS; k++) begin
						bin_cnt_q[k] <= '0;
						bin_sum_q[k] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// a skid beat only exists while a response is held back
	a_skid_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> rsp_valid_q)
		else $error("skid register full without a held response");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && action_s2 == ACT_CLEAR) |=> (grand_cnt_q == '0 && grand_sum_q == '0))
		else $error("clear did not zero the totals");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(!(upd && action_s2 == ACT_CLEAR)) |=> (grand_cnt_q >= $past(grand_cnt_q)))
		else $error("observation total went down without a clear");

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.bucket_hit) |-> (rsp_q.bucket_obs != '0 && rsp_q.all_obs != '0))
		else $error("hit response with a zero count");

endmodule

[dv/tb_bucketed_histogram_accumulator.sv]
// Self-checking testbench for bucketed_histogram_accumulator.
// Runs a directed table and then random items and register settings,
// checking each response beat against an in-bench histogram predictor or a fixed directed expectation.
// Depends on hba_pkg and the RTL top level only.
module tb_bucketed_histogram_accumulator;
	import hba_pkg::*;

	localparam int NBINS = MAX_BUCKETS_DEF;
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic signed [SUM_W-1:0] S_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [SUM_W-1:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam int CFG_LADDER   = 0;
	localparam int CFG_EXTREME  = 1;
	localparam int CFG_SCRAMBLE = 2;
	localparam int SEG_ITEMS    = 240;

	typedef struct {
		bit                     is_reg;
		bit                     chk;
		hba_req_t               req;
		hba_rsp_t               rsp;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [SUM_W-1:0]       reg_val;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	hba_req_t             req_data;
	logic                 rsp_valid;
	logic                 rsp_stall;
	hba_rsp_t             rsp_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SUM_W-1:0]     cfg_data;

	// typed expectation that rides along with the current request beat
	logic                 fix_en;
	hba_rsp_t             fix_rsp;

	// predictor state
	logic [BCNT_W-1:0]       bkt_cnt;
	logic signed [SUM_W-1:0] top_val;
	logic signed [SUM_W-1:0] edge_lo [1:NUM_EDGES];
	logic [CNT_W-1:0]        bin_cnt [NBINS];
	logic signed [SUM_W-1:0] bin_sum [NBINS];
	logic [CNT_W-1:0]        tot_cnt;
	logic signed [SUM_W-1:0] tot_sum;

	hba_rsp_t  pending_rsp [$];
	plan_row_t plan [$];
	int        mismatches = 0;
	int        snd_idle = 0;
	int        rcv_idle = 0;
	int        hold_left = 0;

	bucketed_histogram_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic void hist_clear();
		for (int k = 0; k < NBINS; k++) begin
			bin_cnt[k] = '0;
			bin_sum[k] = '0;
		end
		tot_cnt = '0;
		tot_sum = '0;
	endfunction

	function automatic void hist_reset();
		bkt_cnt = BUCKET_COUNT_RST;
		top_val = TOP_VALUE_RST;
		for (int k = 1; k <= NUM_EDGES; k++)
			edge_lo[k] = EDGES_RST[k-1];
		hist_clear();
	endfunction

	function automatic void hist_config(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] d);
		if (idx == REG_BUCKET_COUNT)
			bkt_cnt = d[BCNT_W-1:0];
		else if (idx == REG_TOP_VALUE)
			top_val = d;
		else if (idx >= REG_EDGE_ONE && idx <= REG_EDGE_FIVE)
			edge_lo[int'(idx - REG_EDGE_ONE) + 1] = d;
	endfunction

	function automatic hba_rsp_t hist_update(hba_req_t r);
		hba_rsp_t o;
		int n;
		int k;
		logic signed [SUM_W-1:0] hi;
		bit done;
		o = '0;
		case (r.action)
		ACT_OBSERVE: begin
			n = (bkt_cnt == 0) ? 1 : (bkt_cnt > NBINS) ? NBINS : int'(bkt_cnt);
			tot_cnt = sat_inc(tot_cnt);
			tot_sum = tot_sum + r.sample_value;
			done = 1'b0;
			for (k = 0; k < n; k++) begin
				// an edge at the most negative value wraps the bound below it to the most positive value
				hi = (k + 1 < n) ? edge_lo[k+1] - 64'sd1 : top_val;
				if (!done && r.sample_value <= hi) begin
					bin_cnt[k] = sat_inc(bin_cnt[k]);
					bin_sum[k] = bin_sum[k] + r.sample_value;
					o.bucket_hit = 1'b1;
					o.hit_index = IDX_W'(k);
					o.bucket_obs = bin_cnt[k];
					o.bucket_total = bin_sum[k];
					done = 1'b1;
				end
			end
		end
		ACT_READ: begin
			o.hit_index = r.read_index;
			if (r.read_index < NBINS) begin
				o.bucket_obs = bin_cnt[r.read_index];
				o.bucket_total = bin_sum[r.read_index];
			end
		end
		ACT_CLEAR: hist_clear();
		default: ;
		endcase
		o.all_obs = tot_cnt;
		o.all_total = tot_sum;
		return o;
	endfunction

	task automatic check_rsp(hba_rsp_t e, hba_rsp_t a);
		if (a.bucket_hit !== e.bucket_hit) begin
			$error("bucket_hit: expected %0d, got %0d", e.bucket_hit, a.bucket_hit);
			mismatches++;
		end
		if (a.hit_index !== e.hit_index) begin
			$error("hit_index: expected %0d, got %0d", e.hit_index, a.hit_index);
			mismatches++;
		end
		if (a.bucket_obs !== e.bucket_obs) begin
			$error("bucket_obs: expected %0d, got %0d", e.bucket_obs, a.bucket_obs);
			mismatches++;
		end
		if (a.bucket_total !== e.bucket_total) begin
			$error("bucket_total: expected %0d, got %0d", e.bucket_total, a.bucket_total);
			mismatches++;
		end
		if (a.all_obs !== e.all_obs) begin
			$error("all_obs: expected %0d, got %0d", e.all_obs, a.all_obs);
			mismatches++;
		end
		if (a.all_total !== e.all_total) begin
			$error("all_total: expected %0d, got %0d", e.all_total, a.all_total);
			mismatches++;
		end
	endtask

	// sample every handshake at the edge; values seen here are the pre-edge ones
	always @(posedge clk) begin : beat_monitor
		hba_rsp_t pred;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("response beat with no expectation waiting");
					mismatches++;
				end else begin
					check_rsp(pending_rsp.pop_front(), rsp_data);
				end
			end
			if (req_valid && !req_stall) begin
				pred = hist_update(req_data);
				if (fix_en)
					pred = fix_rsp;
				pending_rsp.push_back(pred);
			end
			if (cfg_valid && cfg_ready)
				hist_config(cfg_index, cfg_data);
		end
	end

	// receiver stall; a long hold-off is counted down here
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
			end
		end
	end

	function automatic hba_rsp_t mk_rsp(bit hit, int idx, logic [CNT_W-1:0] bobs,
			logic [SUM_W-1:0] btot, logic [CNT_W-1:0] aobs, logic [SUM_W-1:0] atot);
		hba_rsp_t o;
		o.bucket_hit = hit;
		o.hit_index = IDX_W'(idx);
		o.bucket_obs = bobs;
		o.bucket_total = btot;
		o.all_obs = aobs;
		o.all_total = atot;
		return o;
	endfunction

	function automatic void add_op_chk(logic [ACT_W-1:0] a, logic [SUM_W-1:0] v, int i,
			bit chk, hba_rsp_t e);
		plan_row_t row;
		row.is_reg = 1'b0;
		row.chk = chk;
		row.req.action = a;
		row.req.sample_value = v;
		row.req.read_index = IDX_W'(i);
		row.rsp = e;
		row.reg_idx = '0;
		row.reg_val = '0;
		plan.push_back(row);
	endfunction

	function automatic void add_op(logic [ACT_W-1:0] a, logic [SUM_W-1:0] v, int i);
		add_op_chk(a, v, i, 1'b0, '0);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] val);
		plan_row_t row;
		row.is_reg = 1'b1;
		row.chk = 1'b0;
		row.req = '0;
		row.rsp = '0;
		row.reg_idx = idx;
		row.reg_val = val;
		plan.push_back(row);
	endfunction

	task automatic send_item(hba_req_t r, bit chk, hba_rsp_t e);
		while ($urandom_range(0, 99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		fix_en <= chk;
		fix_rsp <= e;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no gap
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [SUM_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic rand_config(int style);
		logic signed [SUM_W-1:0] e [1:NUM_EDGES];
		logic signed [SUM_W-1:0] b;
		logic signed [SUM_W-1:0] t;
		logic [31:0] w;
		logic [BCNT_W-1:0] bc;
		int span;
		w = $urandom;
		b = {{32{w[31]}}, w};
		b = b <<< $urandom_range(0, 28);
		span = $urandom_range(2, 20);
		for (int k = 1; k <= NUM_EDGES; k++) begin
			b = b + 64'($urandom_range(1, 1 << span));
			e[k] = b;
		end
		t = b + 64'($urandom_range(0, 1 << span));
		bc = BCNT_W'($urandom_range(1, NBINS));
		if (style == CFG_EXTREME) begin
			bc = $urandom_range(0, 1) ? 3'd0 : 3'd7;
			e[1] = S_MIN;
			t = S_MAX;
		end else if (style == CFG_SCRAMBLE) begin
			bc = BCNT_W'($urandom_range(0, 7));
			for (int k = 1; k <= NUM_EDGES; k++)
				e[k] = rand64();
			t = rand64();
		end
		// upper data bits of the count register must be ignored
		cfg_write(REG_BUCKET_COUNT, {(SUM_W - BCNT_W)'(rand64()), bc});
		cfg_write(REG_TOP_VALUE, t);
		for (int k = 1; k <= NUM_EDGES; k++)
			cfg_write(REG_EDGE_ONE + CFG_IDX_W'(k - 1), e[k]);
		cfg_valid <= 1'b0;
	endtask

	function automatic hba_req_t rand_req();
		hba_req_t r;
		int p;
		int k;
		logic signed [SUM_W-1:0] base;
		r.action = ACT_OBSERVE;
		r.sample_value = rand64();
		r.read_index = IDX_W'($urandom_range(0, 7));
		p = $urandom_range(0, 99);
		if (p < 18) begin
			r.action = ACT_READ;
		end else if (p < 20) begin
			r.action = ACT_CLEAR;
		end else if (p < 22) begin
			r.action = ACT_NOP;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 55) begin
				// land on or beside a bucket boundary
				k = $urandom_range(1, NUM_EDGES + 1);
				base = (k > NUM_EDGES) ? top_val : edge_lo[k];
				if (p < 40)
					r.sample_value = base + 64'($urandom_range(0, 8)) - 64'd4;
				else
					r.sample_value = base + 64'($urandom_range(0, 1 << 17)) - 64'(1 << 16);
			end else if (p < 65) begin
				case ($urandom_range(0, 3))
				0: r.sample_value = S_MIN;
				1: r.sample_value = S_MAX;
				2: r.sample_value = '0;
				default: r.sample_value = '1;
				endcase
			end
		end
		return r;
	endfunction

	initial begin : stimulus
		hba_req_t r;
		bit prev_reg;
		int style;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		fix_en <= 1'b0;
		fix_rsp <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hist_reset();

		// defaults: edges 16, 256, 4096, 65536, 1048576 and top 2^40
		add_op_chk(ACT_READ, '0, 0, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0));
		add_op_chk(ACT_READ, '0, 7, 1'b1, mk_rsp(0, 7, 0, 0, 0, 0));
		add_op_chk(ACT_OBSERVE, S_MIN, 0, 1'b1, mk_rsp(1, 0, 1, S_MIN, 1, S_MIN));
		add_op(ACT_OBSERVE, 64'd15, 3);
		add_op(ACT_OBSERVE, 64'd16, 0);
		add_op(ACT_OBSERVE, 64'd255, 0);
		add_op(ACT_OBSERVE, 64'd1048576, 0);
		add_op(ACT_OBSERVE, TOP_VALUE_RST, 0);
		add_op(ACT_OBSERVE, TOP_VALUE_RST + 64'd1, 0);
		add_op(ACT_OBSERVE, S_MAX, 5);
		add_op(ACT_NOP, 64'h5A5A_A5A5_0F0F_F0F0, 2);
		add_op(ACT_READ, '0, 6);
		add_op(ACT_READ, '0, 5);
		add_op(ACT_READ, '1, 1);
		add_op_chk(ACT_CLEAR, '1, 7, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0));
		add_op_chk(ACT_READ, '0, 0, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0));
		// zero buckets acts as one, covering everything up to the top
		add_reg(REG_BUCKET_COUNT, 64'd0);
		add_reg(REG_TOP_VALUE, S_MAX);
		add_op_chk(ACT_OBSERVE, S_MAX, 0, 1'b1, mk_rsp(1, 0, 1, S_MAX, 1, S_MAX));
		add_op(ACT_OBSERVE, S_MIN, 0);
		// edge at the most negative value: bucket 0 takes all
		add_reg(REG_BUCKET_COUNT, 64'd7);
		add_reg(REG_EDGE_ONE, S_MIN);
		add_reg(REG_TOP_VALUE, '1);
		add_op(ACT_OBSERVE, '0, 0);
		add_op(ACT_OBSERVE, S_MIN, 0);
		// edges out of order, top below them
		add_reg(REG_BUCKET_COUNT, 64'd3);
		add_reg(REG_EDGE_ONE, 64'd1000);
		add_reg(REG_EDGE_TWO, 64'd10);
		add_reg(REG_TOP_VALUE, -64'sd5);
		add_reg(REG_SPARE, 64'd123);
		add_op(ACT_OBSERVE, 64'd500, 0);
		add_op(ACT_OBSERVE, 64'd2000, 0);
		add_op(ACT_READ, '0, 4);
		add_op(ACT_READ, '0, 2);

		snd_idle = 8;
		rcv_idle = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		prev_reg = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				if (!prev_reg)
					wait_for_results();
				cfg_write(plan[i].reg_idx, plan[i].reg_val);
				prev_reg = 1'b1;
			end else begin
				if (prev_reg)
					cfg_valid <= 1'b0;
				send_item(plan[i].req, plan[i].chk, plan[i].rsp);
				prev_reg = 1'b0;
			end
		end

		for (int seg = 0; seg < 6; seg++) begin
			snd_idle = (seg < 2) ? 8 : (seg < 4) ? 50 : 0;
			rcv_idle = (seg < 2) ? 50 : (seg < 4) ? 8 : 0;
			style = (seg == 1) ? CFG_SCRAMBLE : (seg == 3) ? CFG_EXTREME : CFG_LADDER;
			wait_for_results();
			rand_config(style);
			for (int i = 0; i < SEG_ITEMS; i++) begin
				// fill the pipe against a long receiver hold-off
				if (seg == 4 && i == 60)
					hold_left = 200;
				if (seg == 2 && i == 120)
					wait_for_results();
				r = rand_req();
				send_item(r, 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
